// ===== design/htw_pkg.sv =====
// ----------------------------------------------------------------------------
// htw_pkg: shared definitions for the hierarchical timing wheel
// Sizes of the wheels and node pool, request and response codes, and the
// response beat carried from the sequencer to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

	localparam int NEAR_BITS    = 8;
	localparam int LEVEL_BITS   = 6;
	localparam int OUTER_LEVELS = 4;
	localparam int POOL_SIZE    = 32;

	localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
	localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
	localparam int SLOT_TOTAL  = NEAR_SLOTS + OUTER_LEVELS * LEVEL_SLOTS;
	localparam int SLOT_W      = $clog2(SLOT_TOTAL);
	localparam int NODE_W      = 6;
	localparam int NODE_IW     = $clog2(POOL_SIZE);
	localparam int LV_W        = (OUTER_LEVELS > 1) ? $clog2(OUTER_LEVELS) : 1;
	localparam int ENTRY_W     = 2 * NODE_W;
	localparam int ID_W        = 31;
	localparam int CNT_W       = 6;

	localparam logic [NODE_W-1:0] NODE_NONE = 6'd63;
	localparam logic [63:0] MAX_DIST =
		(64'd1 << (NEAR_BITS + OUTER_LEVELS * LEVEL_BITS)) - 64'd1;
	localparam int TOP_SHIFT = NEAR_BITS + (OUTER_LEVELS - 1) * LEVEL_BITS;
	localparam int TOP_BASE  = NEAR_SLOTS + (OUTER_LEVELS - 1) * LEVEL_SLOTS;

	localparam logic [1:0] REQ_SCHED  = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [1:0] KIND_SCHED  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic             status;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} out_beat_t;

endpackage

`default_nettype wire

// ===== design/htw_slot_mem.sv =====
// ----------------------------------------------------------------------------
// htw_slot_mem: slot list table
// One entry per wheel slot holding list head and tail; one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_slot_mem (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [htw_pkg::SLOT_W-1:0]  waddr,
	input  wire logic [htw_pkg::ENTRY_W-1:0] wdata,
	input  wire logic [htw_pkg::SLOT_W-1:0]  raddr,
	output logic      [htw_pkg::ENTRY_W-1:0] rdata
);

	logic [htw_pkg::ENTRY_W-1:0] mem_q [htw_pkg::SLOT_TOTAL];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/htw_out_reg.sv =====
// ----------------------------------------------------------------------------
// htw_out_reg: response output register
// Holds one response beat toward the consumer and frees itself when the
// beat is taken, so the sequencer can load the next one in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire htw_pkg::out_beat_t beat_in,
	input  wire logic              stall,
	output logic                   can_load,
	output logic                   valid,
	output htw_pkg::out_beat_t     beat_out
);

	logic valid_q;
	htw_pkg::out_beat_t beat_q;

	assign can_load = !valid_q || !stall;
	assign valid    = valid_q;
	assign beat_out = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			beat_q <= beat_in;
		end
	end

endmodule

`default_nettype wire

// ===== design/hierarchical_timing_wheel_unit.sv =====
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_unit: five-level cascading timing wheel
// Schedules, cancels and ticks timers held in a bounded node pool.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table, one slot per cycle
// (SLOT_TOTAL = 512 slots), and holds in_stall high until done. One
// request is taken at a time. A schedule on a full pool answers with a
// fail status and places nothing; a cancel compares one node per cycle
// until a match or the end of the pool; a tick runs the current near
// slot, cascades the outer wheels when the near index is zero,
// re-placing every node of each outer slot it visits, then advances the
// tick count and runs the next near slot. Every response goes out through
// an output register; a stalled consumer holds the sequencer.
`default_nettype none

module hierarchical_timing_wheel_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] delay_ticks,
	input  wire logic [30:0] cancel_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       resp_kind,
	output logic             status,
	output logic [30:0]      timer_id,
	output logic [5:0]       fired_count,
	output logic             last
);

	localparam int SLOT_W  = htw_pkg::SLOT_W;
	localparam int NODE_W  = htw_pkg::NODE_W;
	localparam int NODE_IW = htw_pkg::NODE_IW;
	localparam int ID_W    = htw_pkg::ID_W;
	localparam int POOL    = htw_pkg::POOL_SIZE;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_EMIT  = 4'd2;
	localparam logic [3:0] ST_CXL   = 4'd3;
	localparam logic [3:0] ST_PSUB  = 4'd4;
	localparam logic [3:0] ST_PRD   = 4'd5;
	localparam logic [3:0] ST_PWR   = 4'd6;
	localparam logic [3:0] ST_RRD   = 4'd7;
	localparam logic [3:0] ST_RHD   = 4'd8;
	localparam logic [3:0] ST_RWALK = 4'd9;
	localparam logic [3:0] ST_CRD   = 4'd10;
	localparam logic [3:0] ST_CHD   = 4'd11;
	localparam logic [3:0] ST_CWALK = 4'd12;
	localparam logic [3:0] ST_INC   = 4'd13;
	localparam logic [3:0] ST_DONE  = 4'd14;

	logic [3:0]         state_q;
	logic [63:0]        tick_q;
	logic [ID_W-1:0]    next_id_q;
	logic [NODE_W-1:0]  free_head_q;
	logic [63:0]        expiry_q [POOL];
	logic [ID_W-1:0]    ident_q  [POOL];
	logic [POOL-1:0]    used_q;
	logic [POOL-1:0]    cxl_q;
	logic [NODE_W-1:0]  link_q   [POOL];
	logic [SLOT_W-1:0]  clr_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [NODE_IW-1:0] ci_q;
	logic [ID_W-1:0]    cid_q;
	logic [NODE_W-1:0]  pn_q;
	logic [NODE_W-1:0]  n_q;
	logic [NODE_W-1:0]  cnx_q;
	logic               ret_casc_q;
	logic               phase_q;
	logic [htw_pkg::LV_W-1:0]  lv_q;
	logic               idx_nz_q;
	logic [htw_pkg::CNT_W-1:0] fired_q;
	logic [63:0]        d_q;
	logic [63:0]        clamp_q;
	htw_pkg::out_beat_t res_q;

	logic                          mem_we;
	logic [SLOT_W-1:0]             mem_waddr;
	logic [htw_pkg::ENTRY_W-1:0]   mem_wdata;
	logic [SLOT_W-1:0]             mem_raddr;
	logic [htw_pkg::ENTRY_W-1:0]   mem_rdata;
	logic [NODE_W-1:0]             rd_head;
	logic [NODE_W-1:0]             rd_tail;

	logic               emit;
	htw_pkg::out_beat_t emit_beat;
	logic               can_load;
	htw_pkg::out_beat_t beat_out;

	logic [SLOT_W-1:0]  place_slot;
	logic [SLOT_W-1:0]  casc_slot;
	logic [htw_pkg::LEVEL_BITS-1:0] casc_idx;
	logic [SLOT_W-1:0]  near_slot;
	logic [NODE_IW-1:0] pn_i;
	logic [NODE_IW-1:0] n_i;
	logic [NODE_IW-1:0] cn_i;
	logic [NODE_IW-1:0] fh_i;
	logic [ID_W-1:0]    id_inc;
	logic               accept;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign rd_head   = mem_rdata[2*NODE_W-1:NODE_W];
	assign rd_tail   = mem_rdata[NODE_W-1:0];
	assign pn_i      = pn_q[NODE_IW-1:0];
	assign n_i       = n_q[NODE_IW-1:0];
	assign cn_i      = n_q[NODE_IW-1:0];
	assign fh_i      = free_head_q[NODE_IW-1:0];
	assign near_slot = SLOT_W'(tick_q[htw_pkg::NEAR_BITS-1:0]);
	assign id_inc    = next_id_q + ID_W'(1);

	always_comb begin
		logic        found;
		logic [63:0] ex;
		logic [63:0] e;
		found = 1'b0;
		ex = expiry_q[pn_i];
		e = ex;
		place_slot = '0;
		if (d_q < 64'(htw_pkg::NEAR_SLOTS)) begin
			place_slot = SLOT_W'(ex[htw_pkg::NEAR_BITS-1:0]);
			found = 1'b1;
		end
		for (int k = 0; k < htw_pkg::OUTER_LEVELS - 1; k++) begin
			if (!found && d_q < (64'd1 << (htw_pkg::NEAR_BITS + (k + 1) * htw_pkg::LEVEL_BITS)))
			begin
				place_slot = SLOT_W'(htw_pkg::NEAR_SLOTS + k * htw_pkg::LEVEL_SLOTS)
					+ SLOT_W'(ex[htw_pkg::NEAR_BITS + k * htw_pkg::LEVEL_BITS +:
					htw_pkg::LEVEL_BITS]);
				found = 1'b1;
			end
		end
		if (!found) begin
			if (d_q[63]) begin
				place_slot = near_slot;
			end else begin
				if (d_q > htw_pkg::MAX_DIST) begin
					e = clamp_q;
				end
				place_slot = SLOT_W'(htw_pkg::TOP_BASE)
					+ SLOT_W'(e[htw_pkg::TOP_SHIFT +: htw_pkg::LEVEL_BITS]);
			end
		end
	end

	always_comb begin
		casc_idx  = '0;
		casc_slot = '0;
		for (int k = 0; k < htw_pkg::OUTER_LEVELS; k++) begin
			if (lv_q == htw_pkg::LV_W'(k)) begin
				casc_idx = tick_q[htw_pkg::NEAR_BITS + k * htw_pkg::LEVEL_BITS +:
					htw_pkg::LEVEL_BITS];
				casc_slot = SLOT_W'(htw_pkg::NEAR_SLOTS + k * htw_pkg::LEVEL_SLOTS)
					+ SLOT_W'(casc_idx);
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = {htw_pkg::NODE_NONE, htw_pkg::NODE_NONE};
		mem_raddr = near_slot;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_PRD: begin
				mem_raddr = place_slot;
			end
			ST_PWR: begin
				mem_we = 1'b1;
				if (rd_head >= NODE_W'(POOL)) begin
					mem_wdata = {pn_q, pn_q};
				end else begin
					mem_wdata = {rd_head, pn_q};
				end
			end
			ST_RHD, ST_CHD: begin
				mem_we = 1'b1;
			end
			ST_CRD: begin
				mem_raddr = casc_slot;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_beat = res_q;
		case (state_q)
			ST_EMIT: begin
				emit = 1'b1;
			end
			ST_RWALK: begin
				emit = (n_q < NODE_W'(POOL)) && !cxl_q[n_i];
				emit_beat.kind   = htw_pkg::KIND_FIRED;
				emit_beat.status = htw_pkg::STAT_OK;
				emit_beat.id     = ident_q[n_i];
				emit_beat.cnt    = '0;
				emit_beat.last   = 1'b0;
			end
			ST_DONE: begin
				emit = 1'b1;
				emit_beat.kind   = htw_pkg::KIND_DONE;
				emit_beat.status = htw_pkg::STAT_OK;
				emit_beat.id     = '0;
				emit_beat.cnt    = fired_q;
				emit_beat.last   = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			tick_q      <= '0;
			next_id_q   <= ID_W'(1);
			free_head_q <= '0;
			used_q      <= '0;
			cxl_q       <= '0;
			clr_q       <= '0;
			for (int i = 0; i < POOL; i++) begin
				link_q[i] <= (i + 1 < POOL) ? NODE_W'(i + 1) : htw_pkg::NODE_NONE;
			end
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(htw_pkg::SLOT_TOTAL - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							htw_pkg::REQ_SCHED: begin
								if (free_head_q >= NODE_W'(POOL)) begin
									res_q <= '{htw_pkg::KIND_SCHED, htw_pkg::STAT_FAIL,
										'0, '0, 1'b1};
									state_q <= ST_EMIT;
								end else begin
									free_head_q    <= link_q[fh_i];
									used_q[fh_i]   <= 1'b1;
									cxl_q[fh_i]    <= 1'b0;
									ident_q[fh_i]  <= next_id_q;
									expiry_q[fh_i] <= tick_q + {32'd0, delay_ticks};
									next_id_q <= (id_inc == '0) ? ID_W'(1) : id_inc;
									res_q <= '{htw_pkg::KIND_SCHED, htw_pkg::STAT_OK,
										next_id_q, '0, 1'b1};
									pn_q       <= free_head_q;
									ret_casc_q <= 1'b0;
									state_q    <= ST_PSUB;
								end
							end
							htw_pkg::REQ_CANCEL: begin
								cid_q   <= cancel_id;
								ci_q    <= '0;
								state_q <= ST_CXL;
							end
							htw_pkg::REQ_TICK: begin
								fired_q <= '0;
								phase_q <= 1'b0;
								state_q <= ST_RRD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CXL: begin
					if (used_q[ci_q] && ident_q[ci_q] == cid_q) begin
						cxl_q[ci_q] <= 1'b1;
						res_q <= '{htw_pkg::KIND_CANCEL, htw_pkg::STAT_OK, cid_q, '0, 1'b1};
						state_q <= ST_EMIT;
					end else if (ci_q == NODE_IW'(POOL - 1)) begin
						res_q <= '{htw_pkg::KIND_CANCEL, htw_pkg::STAT_FAIL, cid_q, '0, 1'b1};
						state_q <= ST_EMIT;
					end else begin
						ci_q <= ci_q + NODE_IW'(1);
					end
				end
				ST_PSUB: begin
					d_q     <= expiry_q[pn_i] - tick_q;
					clamp_q <= tick_q + htw_pkg::MAX_DIST;
					state_q <= ST_PRD;
				end
				ST_PRD: begin
					slot_q  <= place_slot;
					state_q <= ST_PWR;
				end
				ST_PWR: begin
					link_q[pn_i] <= htw_pkg::NODE_NONE;
					if (rd_head < NODE_W'(POOL)) begin
						link_q[rd_tail[NODE_IW-1:0]] <= pn_q;
					end
					if (ret_casc_q) begin
						n_q     <= cnx_q;
						state_q <= ST_CWALK;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_RRD: begin
					slot_q  <= near_slot;
					state_q <= ST_RHD;
				end
				ST_RHD: begin
					n_q     <= rd_head;
					state_q <= ST_RWALK;
				end
				ST_RWALK: begin
					if (n_q < NODE_W'(POOL)) begin
						if (!emit || can_load) begin
							if (emit) begin
								fired_q <= fired_q + htw_pkg::CNT_W'(1);
							end
							used_q[n_i] <= 1'b0;
							cxl_q[n_i]  <= 1'b0;
							link_q[n_i] <= free_head_q;
							free_head_q <= n_q;
							n_q         <= link_q[n_i];
						end
					end else if (phase_q) begin
						state_q <= ST_DONE;
					end else if (tick_q[htw_pkg::NEAR_BITS-1:0] == '0) begin
						lv_q    <= '0;
						state_q <= ST_CRD;
					end else begin
						state_q <= ST_INC;
					end
				end
				ST_CRD: begin
					slot_q   <= casc_slot;
					idx_nz_q <= (casc_idx != '0);
					state_q  <= ST_CHD;
				end
				ST_CHD: begin
					n_q     <= rd_head;
					state_q <= ST_CWALK;
				end
				ST_CWALK: begin
					if (n_q < NODE_W'(POOL)) begin
						cnx_q      <= link_q[cn_i];
						pn_q       <= n_q;
						ret_casc_q <= 1'b1;
						state_q    <= ST_PSUB;
					end else if (idx_nz_q
						|| lv_q == htw_pkg::LV_W'(htw_pkg::OUTER_LEVELS - 1)) begin
						state_q <= ST_INC;
					end else begin
						lv_q    <= lv_q + htw_pkg::LV_W'(1);
						state_q <= ST_CRD;
					end
				end
				ST_INC: begin
					tick_q  <= tick_q + 64'd1;
					phase_q <= 1'b1;
					state_q <= ST_RRD;
				end
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	htw_slot_mem u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	htw_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.beat_in  (emit_beat),
		.stall    (out_stall),
		.can_load (can_load),
		.valid    (out_valid),
		.beat_out (beat_out)
	);

	assign resp_kind   = beat_out.kind;
	assign status      = beat_out.status;
	assign timer_id    = beat_out.id;
	assign fired_count = beat_out.cnt;
	assign last        = beat_out.last;

endmodule

`default_nettype wire

// ===== test/hierarchical_timing_wheel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_checker: response predictor and comparator
// Watches the request and response channels of the timing wheel. Every
// accepted request beat updates a private copy of the wheel (node pool,
// slot lists, tick count, id counter) and queues the response beats it
// must cause; every accepted response beat is compared field by field
// with the oldest queued beat.
// ----------------------------------------------------------------------------

module hierarchical_timing_wheel_checker
	import htw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] delay_ticks,
	input  wire logic [30:0] cancel_id,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  resp_kind,
	input  wire logic        status,
	input  wire logic [30:0] timer_id,
	input  wire logic [5:0]  fired_count,
	input  wire logic        last,
	output int               errors,
	output int               pending
);

	localparam int NEAR_MASK  = NEAR_SLOTS - 1;
	localparam int LEVEL_MASK = LEVEL_SLOTS - 1;

	logic [63:0]       tick_now;
	logic [ID_W-1:0]   id_next;
	logic [63:0]       node_due[POOL_SIZE];
	logic [ID_W-1:0]   node_tag[POOL_SIZE];
	logic [1:0]        node_state[POOL_SIZE];
	logic [NODE_W-1:0] node_next[POOL_SIZE];
	logic [NODE_W-1:0] slot_first[SLOT_TOTAL];
	logic [NODE_W-1:0] slot_final[SLOT_TOTAL];
	logic [NODE_W-1:0] free_top;
	out_beat_t         due_beats[$];

	function automatic void post_beat(logic [1:0] kind, logic st, logic [ID_W-1:0] id,
		logic [CNT_W-1:0] cnt);
		due_beats.insert(due_beats.size(),
			'{kind: kind, status: st, id: id, cnt: cnt, last: 1'b0});
	endfunction

	function automatic void slot_append(int s, int n);
		node_next[n] = NODE_NONE;
		if (int'(slot_first[s]) >= POOL_SIZE) begin
			slot_first[s] = NODE_W'(n);
		end else begin
			node_next[slot_final[s]] = NODE_W'(n);
		end
		slot_final[s] = NODE_W'(n);
	endfunction

	function automatic void wheel_place(int n);
		logic [63:0] due;
		logic [63:0] span;
		int s;
		due = node_due[n];
		span = due - tick_now;
		if (span < 64'(NEAR_SLOTS)) begin
			slot_append(int'(due[NEAR_BITS-1:0]), n);
			return;
		end
		for (int k = 0; k + 1 < OUTER_LEVELS; k++) begin
			if (span < (64'd1 << (NEAR_BITS + (k + 1) * LEVEL_BITS))) begin
				s = NEAR_SLOTS + k * LEVEL_SLOTS
					+ (int'(due >> (NEAR_BITS + k * LEVEL_BITS)) & LEVEL_MASK);
				slot_append(s, n);
				return;
			end
		end
		if (span[63]) begin
			slot_append(int'(tick_now[NEAR_BITS-1:0]), n);
			return;
		end
		if (span > MAX_DIST) due = tick_now + MAX_DIST;
		s = TOP_BASE + (int'(due >> TOP_SHIFT) & LEVEL_MASK);
		slot_append(s, n);
	endfunction

	function automatic void fire_slot(ref int fired);
		int s;
		int n;
		int nx;
		s = int'(tick_now[NEAR_BITS-1:0]);
		n = int'(slot_first[s]);
		slot_first[s] = NODE_NONE;
		slot_final[s] = NODE_NONE;
		while (n < POOL_SIZE) begin
			nx = int'(node_next[n]);
			if (!node_state[n][1]) begin
				post_beat(KIND_FIRED, STAT_OK, node_tag[n], '0);
				fired++;
			end
			node_state[n] = 2'b00;
			node_next[n] = free_top;
			free_top = NODE_W'(n);
			n = nx;
		end
	endfunction

	function automatic void cascade_slot(int lv, int idx);
		int s;
		int n;
		int nx;
		s = NEAR_SLOTS + lv * LEVEL_SLOTS + (idx & LEVEL_MASK);
		n = int'(slot_first[s]);
		slot_first[s] = NODE_NONE;
		slot_final[s] = NODE_NONE;
		while (n < POOL_SIZE) begin
			nx = int'(node_next[n]);
			wheel_place(n);
			n = nx;
		end
	endfunction

	function automatic void wheel_clear();
		tick_now = '0;
		id_next = ID_W'(1);
		free_top = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			node_due[i] = '0;
			node_tag[i] = '0;
			node_state[i] = 2'b00;
			node_next[i] = (i + 1 < POOL_SIZE) ? NODE_W'(i + 1) : NODE_NONE;
		end
		for (int i = 0; i < SLOT_TOTAL; i++) begin
			slot_first[i] = NODE_NONE;
			slot_final[i] = NODE_NONE;
		end
	endfunction

	function automatic void wheel_apply(logic [1:0] req, logic [31:0] delay,
		logic [ID_W-1:0] cid);
		int n;
		int fired;
		int idx;
		logic [ID_W-1:0] id;
		logic hit;
		fired = 0;
		hit = 1'b0;
		case (req)
			REQ_SCHED: begin
				if (int'(free_top) >= POOL_SIZE) begin
					post_beat(KIND_SCHED, STAT_FAIL, '0, '0);
				end else begin
					n = int'(free_top);
					free_top = node_next[n];
					id = id_next;
					id_next = id_next + 1'b1;
					if (id_next == '0) id_next = ID_W'(1);
					node_state[n] = 2'b01;
					node_tag[n] = id;
					node_due[n] = tick_now + {32'd0, delay};
					wheel_place(n);
					post_beat(KIND_SCHED, STAT_OK, id, '0);
				end
			end
			REQ_CANCEL: begin
				for (int i = 0; i < POOL_SIZE && !hit; i++) begin
					if (node_state[i][0] && node_tag[i] == cid) begin
						node_state[i][1] = 1'b1;
						hit = 1'b1;
					end
				end
				post_beat(KIND_CANCEL, hit ? STAT_OK : STAT_FAIL, cid, '0);
			end
			REQ_TICK: begin
				fire_slot(fired);
				if (tick_now[NEAR_BITS-1:0] == '0) begin
					for (int lv = 0; lv < OUTER_LEVELS; lv++) begin
						idx = int'(tick_now >> (NEAR_BITS + lv * LEVEL_BITS)) & LEVEL_MASK;
						cascade_slot(lv, idx);
						if (idx != 0) break;
					end
				end
				tick_now++;
				fire_slot(fired);
				post_beat(KIND_DONE, STAT_OK, '0, CNT_W'(fired));
			end
			default: begin
				return;
			end
		endcase
		due_beats[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			wheel_clear();
			due_beats.delete();
			errors = 0;
		end else begin
			if (in_valid && !in_stall) wheel_apply(req_type, delay_ticks, cancel_id);
			if (out_valid && !out_stall) begin
				if (due_beats.size() == 0) begin
					$error("unexpected response beat: resp_kind %0d timer_id %0d",
						resp_kind, timer_id);
					errors++;
				end else begin
					want = due_beats.pop_front();
					if (resp_kind !== want.kind) begin
						$error("resp_kind expected %0d got %0d", want.kind, resp_kind);
						errors++;
					end
					if (status !== want.status) begin
						$error("status expected %0d got %0d", want.status, status);
						errors++;
					end
					if (timer_id !== want.id) begin
						$error("timer_id expected %0d got %0d", want.id, timer_id);
						errors++;
					end
					if (fired_count !== want.cnt) begin
						$error("fired_count expected %0d got %0d", want.cnt, fired_count);
						errors++;
					end
					if (last !== want.last) begin
						$error("last expected %0d got %0d", want.last, last);
						errors++;
					end
				end
			end
		end
		pending = due_beats.size();
	end

endmodule

// ===== test/hierarchical_timing_wheel_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_unit_test: stimulus and verdict
// Drives schedule, cancel, tick and unknown requests into the timing wheel
// under shifting idle patterns, a long response hold-off that backs up
// the block, a drain pause, and a burst of back-to-back ticks. The checker
// beside the block predicts and compares responses.
// ----------------------------------------------------------------------------

module hierarchical_timing_wheel_unit_test;
	import htw_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [31:0] delay_ticks;
	logic [30:0] cancel_id;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  resp_kind;
	logic        status;
	logic [30:0] timer_id;
	logic [5:0]  fired_count;
	logic        last;
	int          errors;
	int          pending;
	int          in_idle;
	int          out_idle;
	int          hold_req;
	int          hold_left;
	int          quiet;
	int          issued;

	hierarchical_timing_wheel_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .delay_ticks(delay_ticks), .cancel_id(cancel_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.resp_kind(resp_kind), .status(status), .timer_id(timer_id),
		.fired_count(fired_count), .last(last)
	);

	hierarchical_timing_wheel_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .delay_ticks(delay_ticks), .cancel_id(cancel_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.resp_kind(resp_kind), .status(status), .timer_id(timer_id),
		.fired_count(fired_count), .last(last),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_beat(logic [1:0] req, logic [31:0] delay, logic [30:0] cid);
		while ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		delay_ticks <= delay;
		cancel_id <= cid;
		if (req == REQ_SCHED) issued++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random();
		int pick;
		logic [31:0] delay;
		logic [30:0] cid;
		pick = $urandom_range(99);
		case ($urandom_range(2))
			0: delay = $urandom_range(40);
			1: delay = $urandom_range(1000);
			default: delay = $urandom;
		endcase
		if ($urandom_range(9) < 7) cid = 31'($urandom_range(issued + 2, 1));
		else cid = 31'($urandom);
		if (pick < 40) send_beat(REQ_SCHED, delay, cid);
		else if (pick < 60) send_beat(REQ_CANCEL, delay, cid);
		else if (pick < 95) send_beat(REQ_TICK, delay, cid);
		else send_beat(REQ_UNKNOWN, delay, cid);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_SCHED;
		delay_ticks = '0;
		cancel_id = '0;
		out_stall = 1'b0;
		hold_req = 0;
		hold_left = 0;
		quiet = 0;
		issued = 0;
		in_idle = 34;
		out_idle = 78;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(REQ_SCHED, 32'd0, '0);
		send_beat(REQ_SCHED, 32'd1, '0);
		send_beat(REQ_SCHED, 32'd255, '0);
		send_beat(REQ_SCHED, 32'h100, '0);
		send_beat(REQ_SCHED, 32'h3FFF, '0);
		send_beat(REQ_SCHED, 32'h4000, '0);
		send_beat(REQ_SCHED, 32'hFFFFF, '0);
		send_beat(REQ_SCHED, 32'h100000, '0);
		send_beat(REQ_SCHED, 32'h3FFFFFF, '0);
		send_beat(REQ_SCHED, 32'h4000000, '0);
		send_beat(REQ_SCHED, 32'hFFFFFFFF, '0);
		send_beat(REQ_CANCEL, '0, 31'd2);
		send_beat(REQ_CANCEL, '0, 31'd2);
		send_beat(REQ_CANCEL, '0, 31'h7FFFFFFF);
		send_beat(REQ_CANCEL, 32'hFFFFFFFF, 31'd0);
		send_beat(REQ_UNKNOWN, 32'hFFFFFFFF, 31'h7FFFFFFF);
		send_beat(REQ_TICK, '0, '0);
		send_beat(REQ_TICK, '0, '0);
		send_beat(REQ_TICK, '0, '0);

		repeat (30) send_random();

		hold_req = 300;
		repeat (25) send_beat(REQ_SCHED, $urandom_range(700), '0);
		drain();

		in_idle = 78;
		out_idle = 34;
		repeat (30) send_random();

		in_idle = 0;
		out_idle = 0;
		repeat (8) send_beat(REQ_TICK, $urandom, 31'($urandom));
		repeat (10) send_random();

		drain();
		repeat (100) @(negedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/htw_pkg.sv
design/htw_slot_mem.sv
design/htw_out_reg.sv
design/hierarchical_timing_wheel_unit.sv
test/hierarchical_timing_wheel_checker.sv
test/hierarchical_timing_wheel_unit_test.sv
